// File: hdl/twdr_pkg.sv
// Constants and tables shared by the two-wheel dead reckoning core.
package twdr_pkg;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_RIGHT   = 2'd0;
  localparam logic [OP_W-1:0] OP_LEFT    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPASS = 2'd2;

  localparam logic RK_POS = 1'b0;
  localparam logic RK_DIR = 1'b1;

  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 15;
  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int CFG_W   = 21;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DISTANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH   = 1'd1;

  localparam logic [CFG_W-1:0] TICK_DISTANCE_RST = 21'd655;
  localparam logic [CFG_W-1:0] TRACK_WIDTH_RST   = 21'd13107;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // Angle units are 1/64 degree.
  localparam int ANG_FULL  = 23040;
  localparam int ANG_HALF  = ANG_FULL / 2;
  localparam int ANG_QTR   = ANG_FULL / 4;
  localparam int ANG_ROUND = ANG_HALF / 2;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] CORDIC_START = 32'd163008219;
  localparam int          ONE_Q14      = 16384;

  // The angle in radians is split into a whole multiple of pi over a half turn and a
  // small remainder that is divided by the half turn with a reciprocal multiply.
  localparam int PI_QUO      = int'(PI_Q30 / ANG_HALF);
  localparam int PI_REM      = int'(PI_Q30 % ANG_HALF);
  localparam int DIV_SHIFT   = 8;
  localparam int DIV_ODD     = ANG_HALF >> DIV_SHIFT;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
  localparam int RECIP_W     = 19;

  localparam int QUO_W      = 31;
  localparam int LOW_W      = 26;
  localparam int RPROD_W    = LOW_W - DIV_SHIFT + RECIP_W;
  localparam int TABLE_LEN  = 24;
  localparam int CNT_W      = 5;

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043836, 32'd133525159,
    32'd67021687,  32'd33543515,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

endpackage

// File: hdl/two_wheel_dead_reckoning_core.sv
// Top level of the two-wheel dead reckoning core: sequencer, shared units and state.

// Each request is one event: a right or left wheel tick or a compass heading. Items are
// handled one at a time and in_stall_o stays high while one is at work. A tick up to and
// including the first forward tick, or an unknown operation, gives no result and the
// block is ready again in the next cycle. A started tick runs its two multiplies through
// the shared multiplier in S_TK1 to S_TK3 and is written to the output register in S_EMIT.
// A compass event passes S_QUAD, which folds the angle into a quadrant, then S_MULPI and
// S_DIV, which turn it into radians with small constant multiplies and a reciprocal
// multiply for the divide by the half turn, then S_CORDIC, which runs one CORDIC rotation
// per cycle in the shift-add unit, and S_MAP, which maps the quadrant; the first compass
// event also passes S_HW1 to S_HW3 to place the wheels. The output register holds a
// finished result until it is taken, and the next request is accepted meanwhile; a result
// that finds the output register still full waits in the sequencer with the input stalled.
module two_wheel_dead_reckoning_core #(
  parameter int CORDIC_STEPS = twdr_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = twdr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [twdr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [twdr_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [twdr_pkg::OP_W-1:0]            operation_i,
  input  logic signed [twdr_pkg::SPEED_W-1:0]  speed_i,
  input  logic [twdr_pkg::ANGLE_W-1:0]         heading_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 result_kind_o,
  output logic signed [twdr_pkg::COORD_W-1:0]  coord_x_o,
  output logic signed [twdr_pkg::COORD_W-1:0]  coord_y_o
);
  import twdr_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_QUAD   = 4'd1;
  localparam logic [ST_W-1:0] S_MULPI  = 4'd2;
  localparam logic [ST_W-1:0] S_DIV    = 4'd3;
  localparam logic [ST_W-1:0] S_CORDIC = 4'd4;
  localparam logic [ST_W-1:0] S_MAP    = 4'd5;
  localparam logic [ST_W-1:0] S_HW1    = 4'd6;
  localparam logic [ST_W-1:0] S_HW2    = 4'd7;
  localparam logic [ST_W-1:0] S_HW3    = 4'd8;
  localparam logic [ST_W-1:0] S_TK1    = 4'd9;
  localparam logic [ST_W-1:0] S_TK2    = 4'd10;
  localparam logic [ST_W-1:0] S_TK3    = 4'd11;
  localparam logic [ST_W-1:0] S_EMIT   = 4'd12;

  localparam int PROD_W = DIR_W + CFG_W + 1;
  localparam int DOUT_W = 48;

  logic [ST_W-1:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0] tick_distance_q, tick_distance_d;
  logic [CFG_W-1:0] track_width_q, track_width_d;
  logic started_q, started_d;
  logic heading_known_q, heading_known_d;
  logic signed [DIR_W-1:0] dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic signed [COORD_W-1:0] rx_q, rx_d, ry_q, ry_d, lx_q, lx_d, ly_q, ly_d;
  logic out_valid_q, out_valid_d;
  logic out_kind_q, out_kind_d;
  logic signed [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  logic [ANGLE_W-1:0] ang_q, ang_d;
  logic [1:0] quad_q, quad_d;
  logic [ANGLE_W-3:0] rem_ang_q, rem_ang_d;
  logic [LOW_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0] cz_q, cz_d;
  logic side_q, side_d;
  logic kind_q, kind_d;

  logic signed [DIR_W-1:0] mul_a;
  logic [CFG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] rnd14, rnd15;
  logic signed [COORD_W-1:0] step14, half15;

  logic accept;
  logic [RPROD_W-1:0] recip_prod;
  logic [QUO_W-1:0] q_small;
  logic signed [31:0] xs, ys;
  logic signed [32:0] atan_ext;
  logic signed [DIR_W-1:0] c_val, s_val;
  logic signed [COORD_W:0] mid_dx, mid_dy;
  logic signed [COORD_W-1:0] mid_x, mid_y, dout_x, dout_y;

  function automatic logic signed [DIR_W-1:0] round_clamp(input logic signed [31:0] v);
    logic signed [32:0] r;
    logic signed [32:0] t;
    t = {v[31], v} + 33'sd8192;
    r = t >>> 14;
    if (r > 33'sd16384) begin
      round_clamp = DIR_W'(ONE_Q14);
    end else if (r < -33'sd16384) begin
      round_clamp = -DIR_W'(ONE_Q14);
    end else begin
      round_clamp = r[DIR_W-1:0];
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] dir_out(input logic signed [DIR_W-1:0] d);
    logic signed [DOUT_W-1:0] v;
    logic signed [DOUT_W-1:0] t;
    v = DOUT_W'(d) <<< FRAC_BITS;
    t = (v + DOUT_W'(8192)) >>> 14;
    dir_out = t[COORD_W-1:0];
  endfunction

  assign in_stall_o    = (state_q != S_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign coord_x_o     = out_x_q;
  assign coord_y_o     = out_y_q;

  always_comb begin
    mul_a = ((state_q == S_TK1) || (state_q == S_HW2)) ? dir_x_q : dir_y_q;
    mul_b = ((state_q == S_TK1) || (state_q == S_TK2)) ? tick_distance_q : track_width_q;
    prod_d = PROD_W'(mul_a) * $signed({1'b0, mul_b});
    rnd14 = (prod_q + PROD_W'(8192)) >>> 14;
    rnd15 = (prod_q + PROD_W'(16384)) >>> 15;
    step14 = rnd14[COORD_W-1:0];
    half15 = rnd15[COORD_W-1:0];

    recip_prod = RPROD_W'(rem_q[LOW_W-1:DIV_SHIFT]) * RPROD_W'(RECIP_MUL);
    q_small = QUO_W'(recip_prod[RPROD_W-1:RECIP_SHIFT]);

    xs = cx_q >>> cnt_q;
    ys = cy_q >>> cnt_q;
    atan_ext = $signed({1'b0, ATAN_Q30[cnt_q]});

    c_val = round_clamp(cx_q);
    s_val = round_clamp(cy_q);

    mid_dx = {lx_q[COORD_W-1], lx_q} - {rx_q[COORD_W-1], rx_q};
    mid_dy = {ly_q[COORD_W-1], ly_q} - {ry_q[COORD_W-1], ry_q};
    mid_x = rx_q + mid_dx[COORD_W:1];
    mid_y = ry_q + mid_dy[COORD_W:1];
    dout_x = dir_out(dir_x_q);
    dout_y = dir_out(dir_y_q);
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    tick_distance_d = tick_distance_q;
    track_width_d   = track_width_q;
    started_d       = started_q;
    heading_known_d = heading_known_q;
    dir_x_d         = dir_x_q;
    dir_y_d         = dir_y_q;
    rx_d            = rx_q;
    ry_d            = ry_q;
    lx_d            = lx_q;
    ly_d            = ly_q;
    out_valid_d     = out_valid_q;
    out_kind_d      = out_kind_q;
    out_x_d         = out_x_q;
    out_y_d         = out_y_q;
    ang_d           = ang_q;
    quad_d          = quad_q;
    rem_ang_d       = rem_ang_q;
    rem_d           = rem_q;
    quo_d           = quo_q;
    cx_d            = cx_q;
    cy_d            = cy_q;
    cz_d            = cz_q;
    side_d          = side_q;
    kind_d          = kind_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_DISTANCE: tick_distance_d = cfg_data_i;
        CFG_TRACK_WIDTH:   track_width_d   = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (operation_i) inside
            OP_RIGHT, OP_LEFT: begin
              side_d = operation_i[0];
              kind_d = RK_POS;
              if (!started_q) begin
                started_d = (speed_i > 0);
              end else begin
                state_d = S_TK1;
              end
            end
            OP_COMPASS: begin
              kind_d  = RK_DIR;
              ang_d   = (heading_angle_i >= ANGLE_W'(ANG_FULL)) ?
                        heading_angle_i - ANGLE_W'(ANG_FULL) : heading_angle_i;
              state_d = S_QUAD;
            end
            default: ;
          endcase
        end
      end
      S_QUAD: begin
        if (ang_q >= ANGLE_W'(3 * ANG_QTR)) begin
          quad_d    = 2'd3;
          rem_ang_d = (ANGLE_W-2)'(ang_q - ANGLE_W'(3 * ANG_QTR));
        end else if (ang_q >= ANGLE_W'(2 * ANG_QTR)) begin
          quad_d    = 2'd2;
          rem_ang_d = (ANGLE_W-2)'(ang_q - ANGLE_W'(2 * ANG_QTR));
        end else if (ang_q >= ANGLE_W'(ANG_QTR)) begin
          quad_d    = 2'd1;
          rem_ang_d = (ANGLE_W-2)'(ang_q - ANGLE_W'(ANG_QTR));
        end else begin
          quad_d    = 2'd0;
          rem_ang_d = ang_q[ANGLE_W-3:0];
        end
        state_d = S_MULPI;
      end
      S_MULPI: begin
        quo_d   = QUO_W'(rem_ang_q) * QUO_W'(PI_QUO);
        rem_d   = LOW_W'(rem_ang_q) * LOW_W'(PI_REM) + LOW_W'(ANG_ROUND);
        state_d = S_DIV;
      end
      S_DIV: begin
        cx_d    = $signed(CORDIC_START);
        cy_d    = '0;
        cz_d    = $signed({2'b00, quo_q + q_small});
        cnt_d   = '0;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        if (!cz_q[32]) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan_ext;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan_ext;
        end
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_MAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MAP: begin
        unique case (quad_q)
          2'd0: begin
            dir_x_d = c_val;
            dir_y_d = s_val;
          end
          2'd1: begin
            dir_x_d = -s_val;
            dir_y_d = c_val;
          end
          2'd2: begin
            dir_x_d = -c_val;
            dir_y_d = -s_val;
          end
          default: begin
            dir_x_d = s_val;
            dir_y_d = -c_val;
          end
        endcase
        state_d = heading_known_q ? S_EMIT : S_HW1;
      end
      S_HW1: begin
        state_d = S_HW2;
      end
      S_HW2: begin
        rx_d    = half15;
        lx_d    = -half15;
        state_d = S_HW3;
      end
      S_HW3: begin
        ry_d            = -half15;
        ly_d            = half15;
        heading_known_d = 1'b1;
        state_d         = S_EMIT;
      end
      S_TK1: begin
        state_d = S_TK2;
      end
      S_TK2: begin
        if (side_q) begin
          lx_d = lx_q + step14;
        end else begin
          rx_d = rx_q + step14;
        end
        state_d = S_TK3;
      end
      S_TK3: begin
        if (side_q) begin
          ly_d = ly_q + step14;
        end else begin
          ry_d = ry_q + step14;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_x_d     = (kind_q == RK_DIR) ? dout_x : mid_x;
          out_y_d     = (kind_q == RK_DIR) ? dout_y : mid_y;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cnt_q           <= '0;
      tick_distance_q <= TICK_DISTANCE_RST;
      track_width_q   <= TRACK_WIDTH_RST;
      started_q       <= 1'b0;
      heading_known_q <= 1'b0;
      dir_x_q         <= '0;
      dir_y_q         <= '0;
      rx_q            <= '0;
      ry_q            <= '0;
      lx_q            <= '0;
      ly_q            <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      tick_distance_q <= tick_distance_d;
      track_width_q   <= track_width_d;
      started_q       <= started_d;
      heading_known_q <= heading_known_d;
      dir_x_q         <= dir_x_d;
      dir_y_q         <= dir_y_d;
      rx_q            <= rx_d;
      ry_q            <= ry_d;
      lx_q            <= lx_d;
      ly_q            <= ly_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    ang_q      <= ang_d;
    quad_q     <= quad_d;
    rem_ang_q  <= rem_ang_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    side_q     <= side_d;
    kind_q     <= kind_d;
    prod_q     <= prod_d;
  end

endmodule

// File: tb/two_wheel_dead_reckoning_core_tb.sv
// Self-checking testbench for the two-wheel dead reckoning core with an odometry scoreboard.
`timescale 1ns / 100ps

module two_wheel_dead_reckoning_core_tb;
  import twdr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] CFG_MAX = 21'd1048576;
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = 21'h1FFFFF;

  localparam longint TURN_UNITS = 23040;
  localparam longint QUARTER_UNITS = 5760;
  localparam longint HALF_TURN_UNITS = 11520;
  localparam longint PI_RAD_Q30 = 64'd3373259426;
  localparam longint CORDIC_X0 = 64'd163008219;
  localparam int CORDIC_PASSES = 16;
  localparam int COORD_FRAC = 16;
  localparam longint UNIT_Q14 = 16384;

  typedef struct packed {
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
  } odo_result_t;

  class odometry_scoreboard;
    odo_result_t expected_results[$];
    int errors;
    logic [CFG_W-1:0] tick_dist;
    logic [CFG_W-1:0] track_w;
    bit started;
    bit heading_known;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [31:0] rw_x;
    logic signed [31:0] rw_y;
    logic signed [31:0] lw_x;
    logic signed [31:0] lw_y;
    longint arctan_q30[CORDIC_PASSES];

    function new();
      errors = 0;
      tick_dist = TICK_DISTANCE_RST;
      track_w = TRACK_WIDTH_RST;
      started = 0;
      heading_known = 0;
      dir_x = '0;
      dir_y = '0;
      rw_x = '0;
      rw_y = '0;
      lw_x = '0;
      lw_y = '0;
      arctan_q30 = '{843314857, 497837829, 263043836, 133525159,
                     67021687, 33543515, 16775851, 8388437,
                     4194283, 2097149, 1048576, 524288,
                     262144, 131072, 65536, 32768};
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_TICK_DISTANCE) begin
        tick_dist = data;
      end else if (idx == CFG_TRACK_WIDTH) begin
        track_w = data;
      end
    endfunction

    function longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint clamp_unit(longint v);
      if (v > UNIT_Q14) begin
        return UNIT_Q14;
      end
      if (v < -UNIT_Q14) begin
        return -UNIT_Q14;
      end
      return v;
    endfunction

    function logic [31:0] dir_to_q16(logic signed [15:0] d);
      longint v;
      v = rnd_shift(longint'(d) <<< COORD_FRAC, 14);
      return v[31:0];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [SPEED_W-1:0] spd,
                               logic [ANGLE_W-1:0] ang);
      odo_result_t res;
      longint a, quad, z, x, y, xs, ys, c, s, cx, cy, hx, hy, dx, dy, mx, my;
      if (op == OP_COMPASS) begin
        a = longint'(ang) % TURN_UNITS;
        quad = a / QUARTER_UNITS;
        z = ((a % QUARTER_UNITS) * PI_RAD_Q30 + HALF_TURN_UNITS / 2) / HALF_TURN_UNITS;
        x = CORDIC_X0;
        y = 0;
        for (int i = 0; i < CORDIC_PASSES; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_q30[i];
          end else begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_q30[i];
          end
        end
        c = clamp_unit(rnd_shift(x, 14));
        s = clamp_unit(rnd_shift(y, 14));
        case (quad)
          0: begin
            cx = c;
            cy = s;
          end
          1: begin
            cx = -s;
            cy = c;
          end
          2: begin
            cx = -c;
            cy = -s;
          end
          default: begin
            cx = s;
            cy = -c;
          end
        endcase
        dir_x = cx[15:0];
        dir_y = cy[15:0];
        if (!heading_known) begin
          hy = rnd_shift(longint'(dir_y) * longint'(track_w), 15);
          hx = rnd_shift(longint'(dir_x) * longint'(track_w), 15);
          rw_x = hy[31:0];
          rw_y = -hx[31:0];
          lw_x = -hy[31:0];
          lw_y = hx[31:0];
          heading_known = 1;
        end
        res.kind = RK_DIR;
        res.x = dir_to_q16(dir_x);
        res.y = dir_to_q16(dir_y);
      end else if (op == OP_RIGHT || op == OP_LEFT) begin
        if (!started) begin
          started = (spd > 0);
          return;
        end
        dx = rnd_shift(longint'(dir_x) * longint'(tick_dist), 14);
        dy = rnd_shift(longint'(dir_y) * longint'(tick_dist), 14);
        if (op == OP_RIGHT) begin
          rw_x = rw_x + dx[31:0];
          rw_y = rw_y + dy[31:0];
        end else begin
          lw_x = lw_x + dx[31:0];
          lw_y = lw_y + dy[31:0];
        end
        mx = longint'(rw_x) + ((longint'(lw_x) - longint'(rw_x)) >>> 1);
        my = longint'(rw_y) + ((longint'(lw_y) - longint'(rw_y)) >>> 1);
        res.kind = RK_POS;
        res.x = mx[31:0];
        res.y = my[31:0];
      end else begin
        return;
      end
      expected_results = {expected_results, res};
    endfunction

    function void check_result(logic kind, logic [31:0] x, logic [31:0] y);
      odo_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: kind %0d x %0d y %0d", kind, $signed(x), $signed(y));
        end
        return;
      end
      want = expected_results.pop_front();
      if (want.kind !== kind || want.x !== x || want.y !== y) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                   want.kind, $signed(want.x), $signed(want.y), kind, $signed(x), $signed(y));
        end
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [OP_W-1:0]            operation_i = '0;
  logic signed [SPEED_W-1:0]  speed_i = '0;
  logic [ANGLE_W-1:0]         heading_angle_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       result_kind_o;
  logic signed [COORD_W-1:0]  coord_x_o;
  logic signed [COORD_W-1:0]  coord_y_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  odometry_scoreboard sb;

  two_wheel_dead_reckoning_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .speed_i(speed_i),
    .heading_angle_i(heading_angle_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_kind_o(result_kind_o),
    .coord_x_o(coord_x_o),
    .coord_y_o(coord_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(result_kind_o, coord_x_o, coord_y_o);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [SPEED_W-1:0] spd,
                              input logic [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    speed_i <= spd;
    heading_angle_i <= ang;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_request(op, spd, ang);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] track);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_TICK_DISTANCE;
    cfg_data_i <= tick;
    @(posedge clk_i);
    cfg_index_i <= CFG_TRACK_WIDTH;
    cfg_data_i <= track;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(CFG_TICK_DISTANCE, tick);
    sb.set_register(CFG_TRACK_WIDTH, track);
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    int sel;
    logic [OP_W-1:0] op;
    logic [ANGLE_W-1:0] ang;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(99) < 2) begin
        wait_drained();
      end
      sel = $urandom_range(99);
      if (sel < 40) begin
        op = OP_RIGHT;
      end else if (sel < 75) begin
        op = OP_LEFT;
      end else if (sel < 95) begin
        op = OP_COMPASS;
      end else begin
        op = OP_UNUSED;
      end
      if ($urandom_range(99) < 85) begin
        ang = ANGLE_W'($urandom_range(23039));
      end else begin
        ang = ANGLE_W'($urandom_range(32767));
      end
      send_request(op, SPEED_W'($urandom), ang);
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: ignored events before start, the first heading, then all quadrants.
    load_config(CFG_MAX, CFG_MAX);
    send_request(OP_RIGHT, 16'sd0, 15'd0);
    send_request(OP_LEFT, -16'sd32768, 15'd32767);
    send_request(OP_UNUSED, 16'sd32767, 15'd32767);
    send_request(OP_COMPASS, 16'sd0, 15'd2000);
    send_request(OP_RIGHT, -16'sd1, 15'd0);
    send_request(OP_LEFT, 16'sd32767, 15'd0);
    send_request(OP_RIGHT, -16'sd32768, 15'd0);
    send_request(OP_LEFT, 16'sd0, 15'd0);
    send_request(OP_UNUSED, 16'sd1, 15'd100);
    send_request(OP_COMPASS, 16'sd0, 15'd0);
    send_request(OP_RIGHT, 16'sd5, 15'd0);
    send_request(OP_COMPASS, 16'sd0, 15'd5759);
    send_request(OP_COMPASS, 16'sd0, 15'd5760);
    send_request(OP_LEFT, 16'sd5, 15'd0);
    send_request(OP_COMPASS, 16'sd0, 15'd11520);
    send_request(OP_RIGHT, 16'sd5, 15'd0);
    send_request(OP_COMPASS, 16'sd0, 15'd17280);
    send_request(OP_LEFT, 16'sd5, 15'd0);
    send_request(OP_COMPASS, 16'sd0, 15'd23039);
    send_request(OP_COMPASS, 16'sd0, 15'd23040);
    send_request(OP_COMPASS, 16'sd0, 15'd32767);
    send_request(OP_RIGHT, 16'sd5, 15'd0);

    // A long straight run on one wheel with the widest step pushes it through the 32-bit wrap.
    load_config(CFG_ALL_ONES, '0);
    send_request(OP_COMPASS, 16'sd0, 15'd0);
    repeat (1075) send_request(OP_RIGHT, SPEED_W'($urandom), ANGLE_W'($urandom));

    load_config('0, TRACK_WIDTH_RST);
    run_random(150, 78, 0);
    load_config(TICK_DISTANCE_RST, 21'd655);
    run_random(150, 0, 78);
    load_config(CFG_W'($urandom_range(1048576)), CFG_W'($urandom_range(1048576)));
    run_random(150, 15, 15);
    load_config(21'd1, 21'd1048575);
    run_random(150, 0, 0);

    in_valid_i <= 1'b0;
    for (int n = 0; n < 20000 && sb.pending() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
